/* rtl/core/aacq_pkg.sv */
// Shared constants, types and the power-of-two table of the AAC spectral quantizer.
package aacq_pkg;

	// Default widths of the sample field.
	localparam int SAMPLE_BITS_DEF   = 32;
	localparam int FRACTION_BITS_DEF = 8;

	// Configuration register.
	localparam int          OFFSET_BITS  = 16;
	localparam logic [15:0] OFFSET_RESET = 16'd26568;

	// Result fields.
	localparam int          QUANT_BITS = 14;
	localparam int          QMAG_BITS  = 13;
	localparam logic [12:0] QMAX       = 13'd8191;

	// Normalised magnitude lies in [2^36, 2^40); roots of the two square-root passes.
	localparam int B_BITS     = 40;
	localparam int ROOT1_BITS = B_BITS / 2;
	localparam int PROD_BITS  = B_BITS + ROOT1_BITS;
	localparam int ROOT2_BITS = PROD_BITS / 2;
	localparam int POW_BITS   = 17;
	localparam int P_BITS     = ROOT2_BITS + POW_BITS;

	// Exponent in sixteenths, split into integer shift and fractional table index.
	localparam int E16_BITS = 12;
	localparam int EXP_BITS = E16_BITS - 4;

	// Sideband carried alongside the root calculations.
	typedef struct packed {
		logic                        neg;
		logic                        zero;
		logic signed [EXP_BITS-1:0]  exp_int;
		logic [3:0]                  exp_frac;
	} aacq_exp_t;

	localparam int EXP_T_BITS = $bits(aacq_exp_t);
	localparam int SIDE1_BITS = EXP_T_BITS + B_BITS;

	// 2^(k/16) in unsigned Q16, rounded to nearest.
	function automatic logic [POW_BITS-1:0] pow16(input logic [3:0] k);
		logic [POW_BITS-1:0] val;
		case (k)
			4'd0:    val = 17'd65536;
			4'd1:    val = 17'd68438;
			4'd2:    val = 17'd71468;
			4'd3:    val = 17'd74632;
			4'd4:    val = 17'd77936;
			4'd5:    val = 17'd81386;
			4'd6:    val = 17'd84990;
			4'd7:    val = 17'd88752;
			4'd8:    val = 17'd92682;
			4'd9:    val = 17'd96785;
			4'd10:   val = 17'd101070;
			4'd11:   val = 17'd105545;
			4'd12:   val = 17'd110218;
			4'd13:   val = 17'd115098;
			4'd14:   val = 17'd120194;
			default: val = 17'd125515;
		endcase
		return val;
	endfunction

endpackage

/* rtl/core/aacq_sqrt.sv */
// Pipelined floor square root, one result bit per register stage, with sideband.
module aacq_sqrt #(
	parameter int RAD_BITS  = aacq_pkg::B_BITS,
	parameter int SIDE_BITS = aacq_pkg::SIDE1_BITS
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     en,
	input  logic                     in_valid,
	input  logic [RAD_BITS-1:0]      in_rad,
	input  logic [SIDE_BITS-1:0]     in_side,
	output logic                     out_valid,
	output logic [RAD_BITS/2-1:0]    out_root,
	output logic [SIDE_BITS-1:0]     out_side
);

	localparam int ROOT_BITS = RAD_BITS / 2;
	localparam int REM_BITS  = ROOT_BITS + 2;

	// One entry per stage; stage j holds the state after j+1 result bits.
	logic                 vld_s  [ROOT_BITS];
	logic [REM_BITS-1:0]  rem_s  [ROOT_BITS];
	logic [ROOT_BITS-1:0] root_s [ROOT_BITS];
	logic [RAD_BITS-1:0]  rad_s  [ROOT_BITS];
	logic [SIDE_BITS-1:0] side_s [ROOT_BITS];

	for (genvar j = 0; j < ROOT_BITS; j++) begin : g_stage
		logic                 vld_in;
		logic [REM_BITS-1:0]  rem_in;
		logic [ROOT_BITS-1:0] root_in;
		logic [RAD_BITS-1:0]  rad_in;
		logic [SIDE_BITS-1:0] side_in;
		logic [REM_BITS-1:0]  trial;
		logic [REM_BITS-1:0]  test;

		// Select the previous stage, or the input port for the first stage.
		if (j == 0) begin : g_first
			assign vld_in  = in_valid;
			assign rem_in  = '0;
			assign root_in = '0;
			assign rad_in  = in_rad;
			assign side_in = in_side;
		end else begin : g_next
			assign vld_in  = vld_s[j-1];
			assign rem_in  = rem_s[j-1];
			assign root_in = root_s[j-1];
			assign rad_in  = rad_s[j-1];
			assign side_in = side_s[j-1];
		end

		// Bring down the next two radicand bits and try the next root bit.
		assign trial = {rem_in[REM_BITS-3:0], rad_in[RAD_BITS-1 -: 2]};
		assign test  = {root_in, 2'b01};

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[j] <= 1'b0;
			end else if (en) begin
				vld_s[j] <= vld_in;
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				rad_s[j]  <= rad_in << 2;
				side_s[j] <= side_in;
				if (trial >= test) begin
					rem_s[j]  <= trial - test;
					root_s[j] <= {root_in[ROOT_BITS-2:0], 1'b1};
				end else begin
					rem_s[j]  <= trial;
					root_s[j] <= {root_in[ROOT_BITS-2:0], 1'b0};
				end
			end
		end
	end

	assign out_valid = vld_s[ROOT_BITS-1];
	assign out_root  = root_s[ROOT_BITS-1];
	assign out_side  = side_s[ROOT_BITS-1];

endmodule

/* rtl/core/aac_spectral_quantizer_unit.sv */
// AAC non-uniform spectral quantizer: |x|^0.75 scaled by the scalefactor, rounded and saturated.
//
//  Channel  Signals                         Contents
//  input    s_tvalid, s_tready, s_tdata     sample, scalefactor
//  output   m_tvalid, m_tready, m_tdata,    quantized; clipped in m_tuser
//           m_tuser
//  config   cfg_valid, cfg_ready, cfg_data  rounding_offset (always ready)
//
// One item is taken per cycle while the pipeline advances, and its result passes 58 pipeline
// registers before it is offered: three stages of normalisation, 20 stages for
// the first square root, two for the split multiply, 30 for the second square root
// and three for scaling and rounding.
// The pipeline advances as a whole whenever the output register is empty or taken;
// a one-entry skid register at the input takes one more item while it holds.
// Reset clears the valid bits, the skid flag and sets the rounding offset to 0.4054.
module aac_spectral_quantizer_unit #(
	parameter int SAMPLE_BITS   = aacq_pkg::SAMPLE_BITS_DEF,
	parameter int FRACTION_BITS = aacq_pkg::FRACTION_BITS_DEF,
	localparam int S_TDATA_BITS = ((SAMPLE_BITS + 8 + 7) / 8) * 8
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    s_tvalid,
	output logic                    s_tready,
	input  logic [S_TDATA_BITS-1:0] s_tdata,  // sample, scalefactor[7:0], zero fill
	output logic                    m_tvalid,
	input  logic                    m_tready,
	output logic [15:0]             m_tdata,  // quantized[13:0], zero fill
	output logic                    m_tuser,  // clipped
	input  logic                    cfg_valid,
	output logic                    cfg_ready,
	input  logic [15:0]             cfg_data  // rounding_offset
);

	localparam int BW     = aacq_pkg::B_BITS;
	localparam int R1W    = aacq_pkg::ROOT1_BITS;
	localparam int PRW    = aacq_pkg::PROD_BITS;
	localparam int R2W    = aacq_pkg::ROOT2_BITS;
	localparam int PW     = aacq_pkg::P_BITS;
	localparam int EW     = aacq_pkg::E16_BITS;
	localparam int XW     = aacq_pkg::EXP_BITS;
	localparam int E_BITS = $clog2(SAMPLE_BITS);
	localparam int SUM_BITS = PW + 1;
	localparam logic signed [EW-1:0] FRAC_TERM = EW'(12 * FRACTION_BITS);
	localparam logic [PW-1:0] LIMIT = PW'(1) << 34;

	// Configuration register.
	logic [15:0] offset_q;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			offset_q <= aacq_pkg::OFFSET_RESET;
		end else if (cfg_valid) begin
			offset_q <= cfg_data;
		end
	end

	// Pipeline advance and input skid register.
	logic                   adv;
	logic                   skid_vld_q;
	logic [SAMPLE_BITS-1:0] skid_sample_q;
	logic [7:0]             skid_sf_q;
	logic                   in_take;
	logic                   in_vld;
	logic [SAMPLE_BITS-1:0] in_sample;
	logic [7:0]             in_sf;

	assign adv      = !m_tvalid || m_tready;
	assign s_tready = !skid_vld_q;
	assign in_take  = s_tvalid && s_tready;
	assign in_vld   = skid_vld_q || in_take;
	assign in_sample = skid_vld_q ? skid_sample_q : s_tdata[SAMPLE_BITS-1:0];
	assign in_sf     = skid_vld_q ? skid_sf_q : s_tdata[SAMPLE_BITS+7:SAMPLE_BITS];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			skid_vld_q <= 1'b0;
		end else if (adv) begin
			skid_vld_q <= 1'b0;
		end else if (in_take) begin
			skid_vld_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (in_take && !adv) begin
			skid_sample_q <= s_tdata[SAMPLE_BITS-1:0];
			skid_sf_q     <= s_tdata[SAMPLE_BITS+7:SAMPLE_BITS];
		end
	end

	// Stage 1: magnitude and sign.
	logic                   vld_s1;
	logic [SAMPLE_BITS-1:0] mag_s1;
	logic                   neg_s1;
	logic [7:0]             sf_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (adv) begin
			vld_s1 <= in_vld;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			neg_s1 <= in_sample[SAMPLE_BITS-1];
			mag_s1 <= in_sample[SAMPLE_BITS-1] ? (~in_sample + SAMPLE_BITS'(1)) : in_sample;
			sf_s1  <= in_sf;
		end
	end

	// Stage 2: leading one position and the normalising shift in nibbles.
	logic [E_BITS-1:0]      lead;
	logic signed [7:0]      lead_gap;
	logic                   vld_s2;
	logic [SAMPLE_BITS-1:0] mag_s2;
	logic                   neg_s2;
	logic                   zero_s2;
	logic [7:0]             sf_s2;
	logic signed [4:0]      nib_s2;

	always_comb begin
		lead = '0;
		for (int i = 0; i < SAMPLE_BITS; i++) begin
			if (mag_s1[i]) begin
				lead = E_BITS'(i);
			end
		end
		lead_gap = 8'sd39 - $signed(8'(lead));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s2 <= 1'b0;
		end else if (adv) begin
			vld_s2 <= vld_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			mag_s2  <= mag_s1;
			neg_s2  <= neg_s1;
			zero_s2 <= (mag_s1 == '0);
			sf_s2   <= sf_s1;
			nib_s2  <= lead_gap[6:2];
		end
	end

	// Stage 3: normalise into [2^36, 2^40) and form the exponent in sixteenths.
	logic [5:0]               shl_amt;
	logic [4:0]               nib_neg;
	logic [5:0]               shr_amt;
	logic [BW-1:0]            norm;
	logic signed [EW-1:0]     nib_ext;
	logic signed [EW-1:0]     sf3;
	logic signed [EW-1:0]     e16;
	logic                     vld_s3;
	logic [BW-1:0]            b_s3;
	aacq_pkg::aacq_exp_t      exp_s3;

	always_comb begin
		shl_amt = {nib_s2[3:0], 2'b00};
		nib_neg = 5'd0 - nib_s2;
		shr_amt = {nib_neg[3:0], 2'b00};
		norm    = nib_s2[4] ? BW'(mag_s2 >> shr_amt) : (BW'(mag_s2) << shl_amt);
		nib_ext = {{(EW-5){nib_s2[4]}}, nib_s2};
		sf3     = $signed({{(EW-8){1'b0}}, sf_s2}) * EW'(3);
		e16     = EW'(300) - FRAC_TERM - sf3 - nib_ext * EW'(48);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s3 <= 1'b0;
		end else if (adv) begin
			vld_s3 <= vld_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			b_s3            <= norm;
			exp_s3.neg      <= neg_s2;
			exp_s3.zero     <= zero_s2;
			exp_s3.exp_int  <= e16[EW-1:4];
			exp_s3.exp_frac <= e16[3:0];
		end
	end

	// First square root: sqrt(b), with b and the exponent riding alongside.
	logic                          sq1_vld;
	logic [R1W-1:0]                sq1_root;
	logic [aacq_pkg::SIDE1_BITS-1:0] sq1_side;
	aacq_pkg::aacq_exp_t           sq1_exp;
	logic [BW-1:0]                 sq1_b;

	aacq_sqrt #(
		.RAD_BITS  (BW),
		.SIDE_BITS (aacq_pkg::SIDE1_BITS)
	) u_sqrt_b (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (adv),
		.in_valid  (vld_s3),
		.in_rad    (b_s3),
		.in_side   ({exp_s3, b_s3}),
		.out_valid (sq1_vld),
		.out_root  (sq1_root),
		.out_side  (sq1_side)
	);

	assign sq1_exp = sq1_side[aacq_pkg::SIDE1_BITS-1:BW];
	assign sq1_b   = sq1_side[BW-1:0];

	// Stage 4: b times sqrt(b) as two 20 by 20 bit partial products.
	logic                     vld_s4;
	logic [BW-1:0]            pp_hi_s4;
	logic [BW-1:0]            pp_lo_s4;
	aacq_pkg::aacq_exp_t      exp_s4;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s4 <= 1'b0;
		end else if (adv) begin
			vld_s4 <= sq1_vld;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			pp_hi_s4 <= BW'(sq1_b[BW-1:BW/2]) * BW'(sq1_root);
			pp_lo_s4 <= BW'(sq1_b[BW/2-1:0]) * BW'(sq1_root);
			exp_s4   <= sq1_exp;
		end
	end

	// Stage 5: sum of the partial products.
	logic                     vld_s5;
	logic [PRW-1:0]           prod_s5;
	aacq_pkg::aacq_exp_t      exp_s5;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s5 <= 1'b0;
		end else if (adv) begin
			vld_s5 <= vld_s4;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			prod_s5 <= {pp_hi_s4, {(BW/2){1'b0}}} + PRW'(pp_lo_s4);
			exp_s5  <= exp_s4;
		end
	end

	// Second square root gives |x|^0.75 of the normalised magnitude.
	logic                            sq2_vld;
	logic [R2W-1:0]                  sq2_root;
	logic [aacq_pkg::EXP_T_BITS-1:0] sq2_side;
	aacq_pkg::aacq_exp_t             sq2_exp;

	aacq_sqrt #(
		.RAD_BITS  (PRW),
		.SIDE_BITS (aacq_pkg::EXP_T_BITS)
	) u_sqrt_p (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (adv),
		.in_valid  (vld_s5),
		.in_rad    (prod_s5),
		.in_side   (exp_s5),
		.out_valid (sq2_vld),
		.out_root  (sq2_root),
		.out_side  (sq2_side)
	);

	assign sq2_exp = sq2_side;

	// Stage 6: scale by the fractional power of two.
	logic                     vld_s6;
	logic [PW-1:0]            p_s6;
	aacq_pkg::aacq_exp_t      exp_s6;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s6 <= 1'b0;
		end else if (adv) begin
			vld_s6 <= sq2_vld;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			p_s6   <= PW'(sq2_root) * PW'(aacq_pkg::pow16(sq2_exp.exp_frac));
			exp_s6 <= sq2_exp;
		end
	end

	// Stage 7: early overflow check and the integer power-of-two shift.
	logic          big_exp;
	logic          pos_exp;
	logic [PW-1:0] limit_shifted;
	logic [XW-1:0] rsh_amt;
	logic [PW-1:0] scaled;
	logic          vld_s7;
	logic [PW-1:0] v_s7;
	logic          over_s7;
	logic          neg_s7;
	logic          zero_s7;

	always_comb begin
		big_exp       = !exp_s6.exp_int[XW-1] && (exp_s6.exp_int >= XW'(30));
		pos_exp       = !exp_s6.exp_int[XW-1] && (exp_s6.exp_int != '0);
		limit_shifted = LIMIT >> exp_s6.exp_int[4:0];
		rsh_amt       = XW'(0) - exp_s6.exp_int;
		scaled        = exp_s6.exp_int[XW-1] ? (p_s6 >> rsh_amt)
		                                     : (p_s6 << exp_s6.exp_int[4:0]);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s7 <= 1'b0;
		end else if (adv) begin
			vld_s7 <= vld_s6;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			v_s7    <= scaled;
			over_s7 <= big_exp || (pos_exp && (p_s6 > limit_shifted));
			neg_s7  <= exp_s6.neg;
			zero_s7 <= exp_s6.zero;
		end
	end

	// Stage 8: rounding, saturation and sign; this is the output register.
	logic [SUM_BITS-1:0]               rounded;
	logic [SUM_BITS-17:0]              q_full;
	logic                              sat;
	logic [aacq_pkg::QMAG_BITS-1:0]    qmag;
	logic [aacq_pkg::QUANT_BITS-1:0]   qsigned;
	logic                              vld_s8;
	logic [aacq_pkg::QUANT_BITS-1:0]   quant_s8;
	logic                              clip_s8;

	always_comb begin
		rounded = {1'b0, v_s7} + SUM_BITS'(offset_q);
		q_full  = rounded[SUM_BITS-1:16];
		sat     = over_s7 || (q_full > (SUM_BITS-16)'(aacq_pkg::QMAX));
		qmag    = sat ? aacq_pkg::QMAX : q_full[aacq_pkg::QMAG_BITS-1:0];
		qsigned = neg_s7 ? (aacq_pkg::QUANT_BITS'(0) - {1'b0, qmag}) : {1'b0, qmag};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s8 <= 1'b0;
		end else if (adv) begin
			vld_s8 <= vld_s7;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			quant_s8 <= zero_s7 ? '0 : qsigned;
			clip_s8  <= !zero_s7 && sat;
		end
	end

	assign m_tvalid = vld_s8;
	assign m_tdata  = {2'b00, quant_s8};
	assign m_tuser  = clip_s8;

endmodule
